@@ rtl/piecewise_linear_distance_lookup_unit_defines.svh @@
// assertion macros for the distance lookup unit
`ifndef PIECEWISE_LINEAR_DISTANCE_LOOKUP_UNIT_DEFINES_SVH
`define PIECEWISE_LINEAR_DISTANCE_LOOKUP_UNIT_DEFINES_SVH

// condition in this cycle implies consequence in the same cycle
`define PLD_ASSERT_NOW(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (r) (a) |-> (b)) \
    else $error("pld assertion failed");

// condition in this cycle implies consequence in the next cycle
`define PLD_ASSERT_NEXT(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (r) (a) |=> (b)) \
    else $error("pld assertion failed");

`endif

@@ rtl/pld_pkg.sv @@
`default_nettype none

package pld_pkg;

  // item kinds
  localparam logic KIND_CONVERT = 1'b0;
  localparam logic KIND_LOAD    = 1'b1;

  // field widths that do not vary
  localparam int INDEX_W = 4;
  localparam int DIST_W  = 6;
  localparam int TOP_W   = 8;

  // distance constants
  localparam logic [TOP_W-1:0]  BASE_CM = 8'd10;
  localparam logic [TOP_W-1:0]  STEP_CM = 8'd5;
  localparam logic [DIST_W-1:0] NEAR_CM = 6'd9;
  localparam logic [DIST_W-1:0] FAR_CM  = 6'd51;

  // quotient is at most five, so three restoring steps suffice
  localparam int DIV_STEPS = 3;

  // result source
  typedef enum logic [1:0] {
    RES_NEAR = 2'd0,
    RES_FAR  = 2'd1,
    RES_BAD  = 2'd2,
    RES_DIV  = 2'd3
  } res_sel_t;

  // controller to datapath
  typedef struct packed {
    logic       capture;
    logic       write_entry;
    logic       advance;
    logic       start_div;
    logic       div_step;
    logic [1:0] div_shift;
    logic       res_load;
    res_sel_t   res_sel;
    logic       out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ge;
    logic seg_bad;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/piecewise_linear_distance_lookup_unit.sv @@
// Infrared distance lookup: converts a raw ADC sample to centimeters through
// a calibration table of NUM_POINTS raw values, point k standing for 10+5k cm.
// Input channel (in_valid / in_stall): kind selects a convert item or a load
// item; a load writes entry_value at entry_index and gives no result, a
// convert gives one result on the output channel (out_valid / out_stall).
// A load leaves the block idle and ready for the next item. A convert scans
// the table one point per cycle through the single table read port:
//   sample at or above point 0:    result NEAR_CM
//   match at point i (i >= 1):     three-step divider, or bad_segment
//   beyond the last point:         result FAR_CM
// The result shows on the output port in the same cycle that the next item
// can be taken. One finished result waits in the output register while the
// next item is accepted and worked on; if it is still stalled when the next
// result is ready, the block holds that result and stalls its input.
// Reset clears the controller and the output valid flag; the table is not
// cleared and every entry must be loaded before a convert reads it.
`default_nettype none
`include "piecewise_linear_distance_lookup_unit_defines.svh"

module piecewise_linear_distance_lookup_unit #(
  parameter int NUM_POINTS  = 9,
  parameter int SAMPLE_BITS = 12
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire                          kind,
  input  wire  [SAMPLE_BITS-1:0]       sample,
  input  wire  [pld_pkg::INDEX_W-1:0]  entry_index,
  input  wire  [SAMPLE_BITS-1:0]       entry_value,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [pld_pkg::DIST_W-1:0]   distance_cm,
  output logic                         bad_segment
);

  localparam int PT_W = $clog2(NUM_POINTS);

  pld_pkg::cmd_t   cmd;
  pld_pkg::sts_t   sts;
  logic [PT_W-1:0] pt;
  logic [PT_W-1:0] rd_addr;

  // sequencer
  pld_ctrl #(
    .NUM_POINTS (NUM_POINTS),
    .PT_W       (PT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd),
    .pt        (pt),
    .rd_addr   (rd_addr)
  );

  // table, compare, divider and result registers
  pld_datapath #(
    .NUM_POINTS  (NUM_POINTS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .PT_W        (PT_W)
  ) u_datapath (
    .clk         (clk),
    .cmd         (cmd),
    .sts         (sts),
    .pt          (pt),
    .rd_addr     (rd_addr),
    .sample      (sample),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .distance_cm (distance_cm),
    .bad_segment (bad_segment)
  );

  // a convert transfer makes the block busy in the next cycle
  `PLD_ASSERT_NEXT(a_convert_busy, clk, rst, in_valid && !in_stall && (kind == pld_pkg::KIND_CONVERT), in_stall)
  // the output register is loaded only when its slot is free
  `PLD_ASSERT_NOW(a_out_slot_free, clk, rst, cmd.out_load, !out_valid || !out_stall)
  // the divider starts only on a strictly decreasing segment
  `PLD_ASSERT_NOW(a_div_good_seg, clk, rst, cmd.start_div, !sts.seg_bad)

endmodule

`default_nettype wire

@@ rtl/pld_datapath.sv @@
`default_nettype none

module pld_datapath #(
  parameter int NUM_POINTS  = 9,
  parameter int SAMPLE_BITS = 12,
  parameter int PT_W        = 4
) (
  input  wire                            clk,
  input  pld_pkg::cmd_t                  cmd,
  output pld_pkg::sts_t                  sts,
  input  wire  [PT_W-1:0]                pt,
  input  wire  [PT_W-1:0]                rd_addr,
  input  wire  [SAMPLE_BITS-1:0]         sample,
  input  wire  [pld_pkg::INDEX_W-1:0]    entry_index,
  input  wire  [SAMPLE_BITS-1:0]         entry_value,
  output logic [pld_pkg::DIST_W-1:0]     distance_cm,
  output logic                           bad_segment
);

  localparam int RW = SAMPLE_BITS + 3;

  logic [SAMPLE_BITS-1:0] mem [NUM_POINTS];
  logic [SAMPLE_BITS-1:0] rd_data;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic [SAMPLE_BITS-1:0] prev;
  logic [SAMPLE_BITS-1:0] den;
  logic [SAMPLE_BITS-1:0] diff;
  logic [RW-1:0]          rem;
  logic [RW-1:0]          trial;
  logic [pld_pkg::DIV_STEPS-1:0] quo;
  logic [pld_pkg::DIV_STEPS:0]   up;
  logic [pld_pkg::TOP_W-1:0]     top;
  logic [pld_pkg::TOP_W-1:0]     interp;
  logic [pld_pkg::DIST_W-1:0]    res_dist;
  logic                          res_bad;
  logic                          index_ok;

  // calibration table, one write and one registered read per cycle
  assign index_ok = 32'(entry_index) < NUM_POINTS;

  always_ff @(posedge clk) begin
    if (cmd.write_entry && index_ok) begin
      mem[PT_W'(entry_index)] <= entry_value;
    end
    rd_data <= mem[rd_addr];
  end

  // scan compares
  assign sts.ge      = sample_r >= rd_data;
  assign sts.seg_bad = prev <= rd_data;

  // sample and previous point
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= sample;
    end
    if (cmd.advance) begin
      prev <= rd_data;
    end
  end

  // restoring divider for 5*(sample-lo)/(hi-lo)
  assign diff  = sample_r - rd_data;
  assign trial = RW'(den) << cmd.div_shift;

  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      rem <= (RW'(diff) << 2) + RW'(diff);
      den <= prev - rd_data;
      quo <= '0;
    end else if (cmd.div_step && (rem >= trial)) begin
      rem <= rem - trial;
      quo[cmd.div_shift] <= 1'b1;
    end
  end

  // distance of the matched point and the rounded-up correction
  assign top    = pld_pkg::BASE_CM + pld_pkg::TOP_W'(pt) * pld_pkg::STEP_CM;
  assign up     = {1'b0, quo} + {{pld_pkg::DIV_STEPS{1'b0}}, (rem != '0)};
  assign interp = top - pld_pkg::TOP_W'(up);

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_sel)
        pld_pkg::RES_NEAR: begin
          res_dist <= pld_pkg::NEAR_CM;
          res_bad  <= 1'b0;
        end
        pld_pkg::RES_FAR: begin
          res_dist <= pld_pkg::FAR_CM;
          res_bad  <= 1'b0;
        end
        pld_pkg::RES_BAD: begin
          res_dist <= top[pld_pkg::DIST_W-1:0];
          res_bad  <= 1'b1;
        end
        default: begin
          res_dist <= interp[pld_pkg::DIST_W-1:0];
          res_bad  <= 1'b0;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      distance_cm <= res_dist;
      bad_segment <= res_bad;
    end
  end

endmodule

`default_nettype wire

@@ rtl/pld_ctrl.sv @@
`default_nettype none

module pld_ctrl #(
  parameter int NUM_POINTS = 9,
  parameter int PT_W       = 4
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire                  kind,
  output logic                 out_valid,
  input  wire                  out_stall,
  input  pld_pkg::sts_t        sts,
  output pld_pkg::cmd_t        cmd,
  output logic [PT_W-1:0]      pt,
  output logic [PT_W-1:0]      rd_addr
);

  localparam logic [PT_W-1:0] LAST_PT  = PT_W'(NUM_POINTS - 1);
  localparam logic [1:0]      LAST_DIV = 2'(pld_pkg::DIV_STEPS - 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_DIV  = 5'b00100,
    S_FIX  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t      state, state_next;
  logic [PT_W-1:0] pt_next;
  logic [1:0]  cnt, cnt_next;
  logic        out_valid_next;
  logic        accept;
  logic        out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // table read address: point 0 outside the scan, next point while scanning, last point held at the end
  always_comb begin
    if ((state == S_SCAN) && (pt != LAST_PT)) begin
      rd_addr = pt + PT_W'(1);
    end else if (state == S_SCAN) begin
      rd_addr = pt;
    end else begin
      rd_addr = '0;
    end
  end

  // next state and commands
  always_comb begin
    state_next     = state;
    pt_next        = pt;
    cnt_next       = cnt;
    out_valid_next = out_valid;
    cmd            = '0;
    cmd.res_sel    = pld_pkg::RES_DIV;
    if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
    case (state)
      S_IDLE: begin
        if (accept && (kind == pld_pkg::KIND_LOAD)) begin
          cmd.write_entry = 1'b1;
        end else if (accept) begin
          cmd.capture = 1'b1;
          pt_next     = '0;
          state_next  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.ge && (pt == '0)) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = pld_pkg::RES_NEAR;
          state_next   = S_DONE;
        end else if (sts.ge && sts.seg_bad) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = pld_pkg::RES_BAD;
          state_next   = S_DONE;
        end else if (sts.ge) begin
          cmd.start_div = 1'b1;
          cnt_next      = '0;
          state_next    = S_DIV;
        end else if (pt == LAST_PT) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = pld_pkg::RES_FAR;
          state_next   = S_DONE;
        end else begin
          cmd.advance = 1'b1;
          pt_next     = pt + PT_W'(1);
        end
      end
      S_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.div_shift = LAST_DIV - cnt;
        if (cnt == LAST_DIV) begin
          state_next = S_FIX;
        end else begin
          cnt_next = cnt + 2'd1;
        end
      end
      S_FIX: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = pld_pkg::RES_DIV;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pt        <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pt        <= pt_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire
